>>> rtl/sau_pkg.sv
// ---------------------------------------------------------------------------
// sau_pkg: shared types and constants
// Widths, fixed-point constants, register indexes and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package sau_pkg;

	localparam int ELEMENTS = 4096;
	localparam int ADDR_W   = $clog2(ELEMENTS);
	localparam int CFG_IDX_W = 3;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA_ONE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA_TWO      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE      = 3'd4;

	typedef logic signed [32:0] mul_op_t;
	typedef logic signed [65:0] mul_prod_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_BP1, S_BP2, S_BP3, S_BP4, S_BP5, S_BP6, S_BP7,
		S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
		S_SQ, S_DV, S_D1, S_D2
	} state_t;

endpackage

`default_nettype wire

>>> rtl/sau_mult.sv
// ---------------------------------------------------------------------------
// sau_mult: shared registered multiplier
// Signed 33 x 33 multiply with the product registered.
// ---------------------------------------------------------------------------
`default_nettype none

module sau_mult (
	input  wire              clk,
	input  sau_pkg::mul_op_t a,
	input  sau_pkg::mul_op_t b,
	output sau_pkg::mul_prod_t prod
);
	import sau_pkg::*;

	mul_prod_t prod_q;

	// register the product
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

>>> rtl/sau_divider.sv
// ---------------------------------------------------------------------------
// sau_divider: iterative unsigned divider
// Restoring division of 64 by 64 bits, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sau_divider (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire [63:0] dividend,
	input  wire [63:0] divisor,
	output logic       busy,
	output logic       done,
	output logic [63:0] quotient
);
	import sau_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic [64:0] diff;

	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift and subtract one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/sau_sqrt.sv
// ---------------------------------------------------------------------------
// sau_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one root bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sau_sqrt (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire [63:0] radicand,
	output logic       done,
	output logic [31:0] root
);
	import sau_pkg::*;

	logic [63:0] rad_q;
	logic [34:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] cat;
	logic [34:0] trial;
	logic [35:0] diff;

	assign cat   = {rem_q[32:0], rad_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = {1'b0, cat} - {1'b0, trial};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// take two radicand bits, decide one root bit
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (!diff[35]) begin
				rem_q  <= diff[34:0];
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= cat;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

>>> rtl/sparse_adam_update.sv
// ---------------------------------------------------------------------------
// sparse_adam_update: fixed-point Adam update of one sparse element
// Moment memories, shared multiplier, iterative square root and divider.
// ---------------------------------------------------------------------------
// One element is handled at a time. An item passes from its input transfer
// to its result through sequencer steps around the shared multiplier, the
// iterative square root unit and the divider, and waits in the last step
// while the output is stalled. An item that opens a new step also computes
// the bias-corrected step size (beta powers, a second square root and
// division) first. After reset the block sweeps all 4096 entries of both
// moment memories to zero, one entry a cycle, before it takes the first
// item; configuration writes are taken at any time.
`default_nettype none

module sparse_adam_update (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_write,
	input  wire [sau_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [31:0]                       cfg_data,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire [11:0]                       element_index,
	input  wire signed [31:0]                gradient,
	input  wire signed [31:0]                param_value,
	input  wire                              first_of_step,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [11:0]                      out_index,
	output logic signed [31:0]               new_param_value,
	output logic [31:0]                      step_number
);
	import sau_pkg::*;

	// configuration
	logic [31:0] lr_q;
	logic [15:0] beta_one_q, beta_two_q, eps_q;
	logic        max_q;

	// step state
	logic [31:0] step_cnt_q;
	logic [16:0] b1p_q, b2p_q;
	logic [31:0] step_q;
	logic [17:0] bc1_q;

	// item registers
	state_t state_q, state_d;
	logic [ADDR_W:0]   clr_q;
	logic [ADDR_W-1:0] idx_q;
	logic signed [31:0] g_q, p_q;
	logic [31:0] m_rd_q, v_rd_q, m_new_q, v_new_q, g2_q, lo_q;
	mul_prod_t   acc_q, a_q;

	// output register
	logic        out_valid_q;
	logic [11:0] out_index_q;
	logic [31:0] out_param_q, out_step_q;

	// moment memories
	logic [31:0] mem_m_q [ELEMENTS];
	logic [31:0] mem_v_q [ELEMENTS];

	logic mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [31:0] mem_wm, mem_wv;

	// units
	mul_op_t   mul_a, mul_b;
	mul_prod_t prod;
	logic sq_start, sq_done;
	logic [63:0] sq_rad;
	logic [31:0] sq_root;
	logic div_start, div_busy, div_done;
	logic [63:0] div_num, div_den, div_quo;

	logic in_xfer, out_free;
	logic [17:0] bc1, bc2;
	logic [31:0] mag;
	logic [40:0] den;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign bc1 = {1'b0, ONE_Q16} - {1'b0, b1p_q};
	assign bc2 = {1'b0, ONE_Q16} - {1'b0, b2p_q};
	assign mag = m_new_q[31] ? (32'd0 - m_new_q) : m_new_q;
	assign den = {1'b0, sq_root, 8'd0} + {25'd0, eps_q};

	sau_mult u_mult (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

	sau_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_rad),
		.done(sq_done), .root(sq_root)
	);

	sau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .busy(div_busy), .done(div_done), .quotient(div_quo)
	);

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q       <= 32'd66;
			beta_one_q <= 16'd58982;
			beta_two_q <= 16'd65470;
			eps_q      <= 16'd43;
			max_q      <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LEARNING_RATE: lr_q <= cfg_data;
				CFG_BETA_ONE:      beta_one_q <= cfg_data[15:0];
				CFG_BETA_TWO:      beta_two_q <= cfg_data[15:0];
				CFG_EPSILON:       eps_q <= cfg_data[15:0];
				CFG_MAXIMIZE:      max_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else         state_q <= state_d;
	end

	// next state and unit controls
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		sq_start  = 1'b0;
		sq_rad    = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = idx_q;
		mem_wm    = m_new_q;
		mem_wv    = v_new_q;
		case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q[ADDR_W-1:0];
				mem_wm    = '0;
				mem_wv    = '0;
				if (clr_q == (ADDR_W+1)'(ELEMENTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				mem_re   = in_valid;
				if (in_valid) state_d = first_of_step ? S_BP1 : S_M1;
			end
			S_BP1: begin
				mul_a   = {16'd0, b1p_q};
				mul_b   = {17'd0, beta_one_q};
				state_d = S_BP2;
			end
			S_BP2: begin
				mul_a   = {16'd0, b2p_q};
				mul_b   = {17'd0, beta_two_q};
				state_d = S_BP3;
			end
			S_BP3: state_d = S_BP4;
			S_BP4: begin
				if (bc1 == 18'd0 || bc1[17]) begin
					state_d = S_M1;
				end else begin
					sq_start = 1'b1;
					sq_rad   = {31'd0, (bc2[17] ? 17'd0 : bc2[16:0]), 16'd0};
					state_d  = S_BP5;
				end
			end
			S_BP5: begin
				mul_a = {1'b0, lr_q};
				mul_b = {1'b0, sq_root};
				if (sq_done) state_d = S_BP6;
			end
			S_BP6: begin
				div_start = 1'b1;
				div_num   = prod[63:0];
				div_den   = {46'd0, bc1_q};
				state_d   = S_BP7;
			end
			S_BP7: if (div_done) state_d = S_M1;
			S_M1: begin
				mul_a   = {17'd0, beta_one_q};
				mul_b   = {m_rd_q[31], m_rd_q};
				state_d = S_M2;
			end
			S_M2: begin
				mul_a   = {16'd0, 17'(ONE_Q16 - {1'b0, beta_one_q})};
				mul_b   = {g_q[31], g_q};
				state_d = S_M3;
			end
			S_M3: begin
				mul_a   = {g_q[31], g_q};
				mul_b   = {g_q[31], g_q};
				state_d = S_M4;
			end
			S_M4: begin
				mul_a   = {17'd0, beta_two_q};
				mul_b   = {1'b0, v_rd_q};
				state_d = S_M5;
			end
			S_M5: begin
				mul_a   = {16'd0, 17'(ONE_Q16 - {1'b0, beta_two_q})};
				mul_b   = {1'b0, g2_q};
				state_d = S_M6;
			end
			S_M6: state_d = S_M7;
			S_M7: begin
				mem_we   = 1'b1;
				sq_start = 1'b1;
				sq_rad   = {v_new_q, 32'd0};
				state_d  = S_SQ;
			end
			S_SQ: begin
				if (sq_done) begin
					div_start = 1'b1;
					div_num   = {mag, 32'd0};
					div_den   = {23'd0, (den == 41'd0) ? 41'd1 : den};
					state_d   = S_DV;
				end
			end
			S_DV: begin
				mul_a = {1'b0, step_q};
				mul_b = {1'b0, div_quo[63:32]};
				if (div_done) state_d = S_D1;
			end
			S_D1: begin
				mul_a   = {1'b0, step_q};
				mul_b   = {1'b0, lo_q};
				state_d = S_D2;
			end
			S_D2: begin
				mul_a = {1'b0, step_q};
				mul_b = {1'b0, lo_q};
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// moment memories: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_m_q[mem_waddr] <= mem_wm;
			mem_v_q[mem_waddr] <= mem_wv;
		end
		if (mem_re) begin
			m_rd_q <= mem_m_q[element_index[ADDR_W-1:0]];
			v_rd_q <= mem_v_q[element_index[ADDR_W-1:0]];
		end
	end

	// clear sweep and step state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			step_cnt_q <= '0;
			b1p_q      <= ONE_Q16;
			b2p_q      <= ONE_Q16;
			step_q     <= '0;
		end else begin
			case (state_q)
				S_CLR: clr_q <= clr_q + (ADDR_W+1)'(1);
				S_BP1: if (step_cnt_q != 32'hFFFF_FFFF) step_cnt_q <= step_cnt_q + 32'd1;
				S_BP2: b1p_q <= 17'((prod + 66'sd32768) >>> 16);
				S_BP3: b2p_q <= 17'((prod + 66'sd32768) >>> 16);
				S_BP4: if (bc1 == 18'd0 || bc1[17]) step_q <= '0;
				S_BP7: begin
					if (div_done) step_q <= (|div_quo[63:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
				end
				default: ;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					idx_q <= element_index[ADDR_W-1:0];
					p_q   <= param_value;
					if (max_q) begin
						g_q <= (gradient == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -gradient;
					end else begin
						g_q <= gradient;
					end
				end
			end
			S_BP4: bc1_q <= bc1;
			S_M2: acc_q <= prod;
			S_M3: acc_q <= acc_q + prod + 66'sd32768;
			S_M4: begin
				if ((acc_q >>> 16) > 66'sd2147483647)       m_new_q <= 32'h7FFF_FFFF;
				else if ((acc_q >>> 16) < -66'sd2147483648) m_new_q <= 32'h8000_0000;
				else                                        m_new_q <= 32'(acc_q >>> 16);
				g2_q <= (|prod[65:48]) ? 32'hFFFF_FFFF : prod[47:16];
			end
			S_M5: acc_q <= prod;
			S_M6: begin
				if (|((acc_q + prod + 66'sd32768) >>> 48)) v_new_q <= 32'hFFFF_FFFF;
				else v_new_q <= 32'((acc_q + prod + 66'sd32768) >>> 16);
			end
			S_DV: if (div_done) lo_q <= div_quo[31:0];
			S_D1: a_q <= prod;
			default: ;
		endcase
	end

	// final step: apply the update, saturate, load the output register
	logic [48:0] dsum;
	logic [33:0] delta;
	logic signed [35:0] np;

	always_comb begin
		dsum  = {16'd0, a_q[16:0], 16'd0} + {1'b0, prod[63:16]};
		if (a_q >= 66'sd131072)        delta = 34'h2_0000_0000;
		else if (dsum > 49'h2_0000_0000) delta = 34'h2_0000_0000;
		else                           delta = dsum[33:0];
		if (m_new_q[31]) np = {{4{p_q[31]}}, p_q} + {2'b00, delta};
		else             np = {{4{p_q[31]}}, p_q} - {2'b00, delta};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_D2 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_D2 && out_free) begin
			out_index_q <= 12'(idx_q);
			out_step_q  <= step_cnt_q;
			if (np > 36'sd2147483647)       out_param_q <= 32'h7FFF_FFFF;
			else if (np < -36'sd2147483648) out_param_q <= 32'h8000_0000;
			else                            out_param_q <= np[31:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign out_index       = out_index_q;
	assign new_param_value = out_param_q;
	assign step_number     = out_step_q;

	// items enter only when the sequencer is idle
	a_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> (state_q == S_IDLE)) else $error("item taken while busy");

	// the divider is never restarted mid-division
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");

	// moments are written only by the clear sweep or the write-back step
	a_mem_we: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLR || state_q == S_M7))
		else $error("unexpected moment write");

endmodule

`default_nettype wire
